// File: rtl/core/ccfd_pkg.sv
// Shared constants, status codes and the CRC-32 byte update for the COBS fix deframer.
`timescale 1ns / 1ps

package ccfd_pkg;

    localparam int FRAME_BYTES_DEF = 42;
    localparam int MIN_DECODED_DEF = 40;
    localparam int CRC_SPAN_DEF    = 32;

    // Four 64-bit fix words are read from the start of the decoded payload.
    localparam int FIX_BYTES = 32;
    localparam int WORD_BITS = 64;

    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = 9'h1FF;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [7:0] FULL_CODE = 8'hFF;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_LEN   = 2'd1;
    localparam status_t ST_SHORT     = 2'd2;
    localparam status_t ST_CRC_ERR   = 2'd3;

    // Status, four fix words, then zero fill to a whole number of bytes.
    localparam int RESULT_BITS = 2 + 4 * WORD_BITS;
    localparam int OUT_DATA_W  = ((RESULT_BITS + 7) / 8) * 8;

    // Reflected CRC-32 over one byte, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/core/cobs_crc32_fix_deframer_top.sv
// COBS deframer with CRC-32 check that reports one fix result per frame delimiter.
// A result is registered and is valid on m_tvalid in the cycle after its delimiter item is accepted.
// Throughput: one received byte per cycle while s_tready is high; the byte decode and CRC update are combinational.
// s_tready drops only while a finished result waits in the output register and m_tready is low.
// Reset clears the decoder state, the counters and the output valid flag, and loads CRC_INIT into the CRC.
// The payload bytes are not cleared; each frame overwrites the entries it decodes.
`timescale 1ns / 1ps

module cobs_crc32_fix_deframer_top #(
    parameter int FRAME_BYTES = ccfd_pkg::FRAME_BYTES_DEF,
    parameter int MIN_DECODED = ccfd_pkg::MIN_DECODED_DEF,
    parameter int CRC_SPAN    = ccfd_pkg::CRC_SPAN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frame_status[1:0], lat_bits, lon_bits, alt_bits, head_bits, zero fill
    output logic [ccfd_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import ccfd_pkg::*;

    localparam int STORE_DEPTH = ((CRC_SPAN + 4) > FIX_BYTES) ? (CRC_SPAN + 4) : FIX_BYTES;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int FILL_W = OUT_DATA_W - RESULT_BITS;

    logic [7:0]       group_left_reg, group_left_next;
    logic             group_full_reg, group_full_next;
    logic             zero_pending_reg, zero_pending_next;
    logic [CNT_W-1:0] enc_count_reg, enc_count_next;
    logic [CNT_W-1:0] dec_count_reg, dec_count_next;
    logic [31:0]      crc_reg, crc_next;
    logic [7:0]       store_reg [STORE_DEPTH];

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic       in_fire;
    logic       is_delim;
    logic       emit_en;
    logic [7:0] emit_byte;
    logic       store_we;
    logic [7:0] left_dec;

    status_t                  status;
    logic [31:0]              rx_crc;
    logic [4*WORD_BITS-1:0]   fix_words;
    logic [OUT_DATA_W-1:0]    result;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign is_delim = (s_tdata == 8'h00);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Decoder step for one non-delimiter byte. At most one byte is emitted per item:
    // either the deferred zero ahead of a new group or a data byte of the open group.
    always_comb
    begin
        group_left_next   = group_left_reg;
        group_full_next   = group_full_reg;
        zero_pending_next = zero_pending_reg;
        enc_count_next    = enc_count_reg;
        emit_en           = 1'b0;
        emit_byte         = 8'h00;
        left_dec          = group_left_reg - 8'd1;

        if (in_fire)
        begin
            if (is_delim)
            begin
                group_left_next   = 8'h00;
                group_full_next   = 1'b0;
                zero_pending_next = 1'b0;
                enc_count_next    = '0;
            end
            else
            begin
                if (enc_count_reg != COUNT_MAX)
                begin
                    enc_count_next = enc_count_reg + 9'd1;
                end
                if (group_left_reg == 8'h00)
                begin
                    emit_en           = zero_pending_reg;
                    group_left_next   = s_tdata - 8'd1;
                    group_full_next   = (s_tdata == FULL_CODE);
                    zero_pending_next = (s_tdata == 8'd1);
                end
                else
                begin
                    emit_en         = 1'b1;
                    emit_byte       = s_tdata;
                    group_left_next = left_dec;
                    if (left_dec == 8'h00)
                    begin
                        zero_pending_next = !group_full_reg;
                    end
                end
            end
        end
    end

    assign store_we = emit_en && (dec_count_reg < 9'(STORE_DEPTH));

    always_comb
    begin
        dec_count_next = dec_count_reg;
        crc_next       = crc_reg;
        if (in_fire && is_delim)
        begin
            dec_count_next = '0;
            crc_next       = CRC_INIT;
        end
        else if (emit_en)
        begin
            if (dec_count_reg < 9'(CRC_SPAN))
            begin
                crc_next = crc32_byte(crc_reg, emit_byte);
            end
            if (dec_count_reg != COUNT_MAX)
            begin
                dec_count_next = dec_count_reg + 9'd1;
            end
        end
    end

    // Frame check at the delimiter, using the state before this item.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rx_crc[8*i +: 8] = store_reg[CRC_SPAN + i];
        end
        for (int i = 0; i < FIX_BYTES; i++)
        begin
            fix_words[8*i +: 8] = store_reg[i];
        end

        priority if (({1'b0, enc_count_reg} + 10'd1) != 10'(FRAME_BYTES))
        begin
            status = ST_BAD_LEN;
        end
        else if (dec_count_reg < 9'(MIN_DECODED))
        begin
            status = ST_SHORT;
        end
        else if (~crc_reg != rx_crc)
        begin
            status = ST_CRC_ERR;
        end
        else
        begin
            status = ST_OK;
        end

        result = {{FILL_W{1'b0}},
                  (status == ST_OK) ? fix_words : {(4*WORD_BITS){1'b0}},
                  status};
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (in_fire && is_delim)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_left_reg   <= 8'h00;
            group_full_reg   <= 1'b0;
            zero_pending_reg <= 1'b0;
            enc_count_reg    <= '0;
            dec_count_reg    <= '0;
            crc_reg          <= CRC_INIT;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            group_left_reg   <= group_left_next;
            group_full_reg   <= group_full_next;
            zero_pending_reg <= zero_pending_next;
            enc_count_reg    <= enc_count_next;
            dec_count_reg    <= dec_count_next;
            crc_reg          <= crc_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[dec_count_reg[IDX_W-1:0]] <= emit_byte;
        end
        if (in_fire && is_delim)
        begin
            m_data_reg <= result;
        end
    end

endmodule
